// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions of the depth map merge block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant violated");

// When the antecedent holds, the consequence holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle consequence missing");

// When the antecedent holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle consequence missing");

`endif

// ===== rtl/dsmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth map merge package
// Types, codes and command/status structures shared by the block's files.
// ----------------------------------------------------------------------------
package dsmm_pkg;

   typedef logic [1:0]         op_type;
   typedef logic [7:0]         coord_type;
   typedef logic signed [31:0] depth_type;
   typedef logic signed [15:0] sim_type;
   typedef logic [1:0]         csr_index_type;
   typedef logic [8:0]         csr_data_type;

   typedef struct packed {
      depth_type depth;
      sim_type   sim;
   } cell_type;

   localparam op_type OP_WRITE  = 2'd0;
   localparam op_type OP_READ   = 2'd1;
   localparam op_type OP_MERGE  = 2'd2;
   localparam op_type OP_COARSE = 2'd3;

   localparam csr_index_type CSR_MAP_WIDTH     = 2'd0;
   localparam csr_index_type CSR_MAP_HEIGHT    = 2'd1;
   localparam csr_index_type CSR_COARSE_FACTOR = 2'd2;

   localparam int CSR_FACTOR_BITS = 5;

   localparam depth_type DEPTH_INVALID = -32'sd65536;
   localparam sim_type   SIM_ONE       = 16'sd16384;

   typedef struct packed {
      logic accept;
      logic clear;
      logic fine_rd;
      logic fine_commit;
      logic coarse_mul;
      logic win_init;
      logic win_reload;
      logic scan_rd;
      logic win_wr;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic   clear_last;
      op_type op;
      logic   din_valid;
      logic   empty;
      logic   win_last;
      logic   best;
   } status_type;

endpackage

// ===== rtl/dsmm_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operation item into the block.
// ----------------------------------------------------------------------------
interface dsmm_req_if;
   import dsmm_pkg::*;

   logic      valid;
   logic      ready;
   op_type    op;
   coord_type cell_x;
   coord_type cell_y;
   depth_type depth_in;
   sim_type   sim_in;

   modport source (output valid, output op, output cell_x, output cell_y,
                   output depth_in, output sim_in, input ready);
   modport sink   (input valid, input op, input cell_x, input cell_y,
                   input depth_in, input sim_in, output ready);
endinterface

// ===== rtl/dsmm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item out of the block.
// ----------------------------------------------------------------------------
interface dsmm_rsp_if;
   import dsmm_pkg::*;

   logic      valid;
   logic      ready;
   depth_type depth_out;
   sim_type   sim_out;
   logic      updated;

   modport source (output valid, output depth_out, output sim_out, output updated,
                   input ready);
   modport sink   (input valid, input depth_out, input sim_out, input updated,
                   output ready);
endinterface

// ===== rtl/dsmm_dpath.sv =====
// ----------------------------------------------------------------------------
// Depth map merge datapath
// Cell memory, configuration registers, window counters and result registers.
// ----------------------------------------------------------------------------
module dsmm_dpath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_FACTOR = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dsmm_pkg::cmd_type      cmd,
   output dsmm_pkg::status_type   status,
   input  dsmm_pkg::op_type       req_op,
   input  dsmm_pkg::coord_type    req_cell_x,
   input  dsmm_pkg::coord_type    req_cell_y,
   input  dsmm_pkg::depth_type    req_depth_in,
   input  dsmm_pkg::sim_type      req_sim_in,
   input  logic                   csr_we,
   input  dsmm_pkg::csr_index_type csr_index,
   input  dsmm_pkg::csr_data_type csr_wdata,
   output dsmm_pkg::depth_type    depth_out,
   output dsmm_pkg::sim_type      sim_out,
   output logic                   updated
);
   import dsmm_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int FW    = $clog2(MAX_FACTOR + 1);
   localparam int XI    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YI    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PW    = 8 + FW;
   localparam int SW0   = (PW > XW) ? PW : XW;
   localparam int SW    = ((SW0 > YW) ? SW0 : YW) + 2;
   localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int F_RST = (MAX_FACTOR < 2) ? MAX_FACTOR : 2;

   localparam logic [31:0]          MAXW_U   = 32'(MAX_WIDTH);
   localparam logic [31:0]          MAXH_U   = 32'(MAX_HEIGHT);
   localparam logic [31:0]          MAXF_U   = 32'(MAX_FACTOR);
   localparam logic [AW-1:0]        ROW_STEP = AW'(MAX_WIDTH);
   localparam logic [AW-1:0]        LAST_ADR = AW'(DEPTH - 1);
   localparam logic signed [SW-1:0] ONE_S    = SW'(1);

   cell_type cell_mem [DEPTH];

   logic [XW-1:0] width_ff, width_in;
   logic [YW-1:0] height_ff, height_in;
   logic [FW-1:0] factor_ff, factor_in;
   logic [CSR_FACTOR_BITS-1:0] factor_wr;

   op_type        op_ff;
   coord_type     cell_x_ff, cell_y_ff;
   depth_type     depth_ff;
   sim_type       sim_ff;
   logic [AW-1:0] fine_addr_ff;
   logic [PW-1:0] cxf_ff, cyf_ff;

   logic [XI-1:0] x_ff, x_in, xb0_ff, xb1_ff;
   logic [YI-1:0] y_ff, y_in, yb0_ff, yb1_ff;
   logic [AW-1:0] row_ff, row_in;
   logic [AW-1:0] win_addr;
   logic [AW-1:0] clr_ff;
   logic          adv;

   logic signed [SW-1:0] cxf_s, cyf_s, lo_s, hi_s, wm1_s, hm1_s;
   logic signed [SW-1:0] x0_s, x1_s, y0_s, y1_s, x0c_s, x1c_s, y0c_s, y1c_s;
   logic [FW-1:0]        lo_f, hi_f;

   cell_type      rd_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   cell_type      mem_wdata;

   logic pend_ff, best_ff, best_now;
   logic in_map, din_valid, do_write;

   depth_type res_depth_ff, out_depth_ff;
   sim_type   res_sim_ff, out_sim_ff;
   logic      res_upd_ff, out_upd_ff;

   // Configuration: values are clamped to their legal range when written; factor uses low bits.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      factor_in = factor_ff;
      factor_wr = csr_wdata[CSR_FACTOR_BITS-1:0];
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_WIDTH: begin
               if (csr_wdata == '0) width_in = XW'(1);
               else if (32'(csr_wdata) > MAXW_U) width_in = XW'(MAX_WIDTH);
               else width_in = XW'(csr_wdata);
            end
            CSR_MAP_HEIGHT: begin
               if (csr_wdata == '0) height_in = YW'(1);
               else if (32'(csr_wdata) > MAXH_U) height_in = YW'(MAX_HEIGHT);
               else height_in = YW'(csr_wdata);
            end
            CSR_COARSE_FACTOR: begin
               if (factor_wr == '0) factor_in = FW'(1);
               else if (32'(factor_wr) > MAXF_U) factor_in = FW'(MAX_FACTOR);
               else factor_in = FW'(factor_wr);
            end
            default: begin
            end
         endcase
      end
   end

   // Coarse window bounds, clipped to the map.
   always_comb begin
      lo_f  = factor_ff >> 1;
      hi_f  = factor_ff[0] ? lo_f : lo_f - FW'(1);
      cxf_s = SW'(cxf_ff);
      cyf_s = SW'(cyf_ff);
      lo_s  = SW'(lo_f);
      hi_s  = SW'(hi_f);
      wm1_s = SW'(width_ff) - ONE_S;
      hm1_s = SW'(height_ff) - ONE_S;
      x0_s  = cxf_s - lo_s;
      x1_s  = cxf_s + hi_s;
      y0_s  = cyf_s - lo_s;
      y1_s  = cyf_s + hi_s;
      x0c_s = x0_s[SW-1] ? '0 : x0_s;
      y0c_s = y0_s[SW-1] ? '0 : y0_s;
      x1c_s = (x1_s > wm1_s) ? wm1_s : x1_s;
      y1c_s = (y1_s > hm1_s) ? hm1_s : y1_s;
   end

   assign adv      = cmd.scan_rd | cmd.win_wr;
   assign win_addr = row_ff + AW'(x_ff);

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      row_in = row_ff;
      priority if (cmd.win_init) begin
         x_in   = x0c_s[XI-1:0];
         y_in   = y0c_s[YI-1:0];
         row_in = AW'(y0c_s[YI-1:0]) * ROW_STEP;
      end else if (cmd.win_reload) begin
         x_in   = xb0_ff;
         y_in   = yb0_ff;
         row_in = AW'(yb0_ff) * ROW_STEP;
      end else if (adv) begin
         if (x_ff == xb1_ff) begin
            x_in   = xb0_ff;
            y_in   = y_ff + 1'b1;
            row_in = row_ff + ROW_STEP;
         end else begin
            x_in = x_ff + 1'b1;
         end
      end
   end

   assign in_map    = (SW'(cell_x_ff) < SW'(width_ff)) && (SW'(cell_y_ff) < SW'(height_ff));
   assign din_valid = depth_ff > DEPTH_INVALID;
   assign do_write  = in_map && ((op_ff == OP_WRITE) ||
                      ((op_ff == OP_MERGE) && din_valid && (sim_ff < rd_ff.sim)));
   assign best_now  = best_ff && !(pend_ff && (sim_ff > rd_ff.sim));

   // Memory port control.
   always_comb begin
      mem_we    = cmd.clear | cmd.win_wr | (cmd.fine_commit & do_write);
      mem_re    = cmd.scan_rd | (cmd.fine_rd & in_map);
      mem_raddr = cmd.scan_rd ? win_addr : fine_addr_ff;
      priority if (cmd.clear) begin
         mem_waddr = clr_ff;
         mem_wdata = '{depth: DEPTH_INVALID, sim: SIM_ONE};
      end else if (cmd.win_wr) begin
         mem_waddr = win_addr;
         mem_wdata = '{depth: depth_ff, sim: sim_ff};
      end else begin
         mem_waddr = fine_addr_ff;
         mem_wdata = '{depth: depth_ff, sim: sim_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= cell_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= XW'(W_RST);
         height_ff <= YW'(H_RST);
         factor_ff <= FW'(F_RST);
         clr_ff    <= '0;
         pend_ff   <= 1'b0;
         best_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         factor_ff <= factor_in;
         pend_ff   <= cmd.scan_rd;
         best_ff   <= cmd.accept ? 1'b1 : best_now;
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      row_ff <= row_in;
      if (cmd.accept) begin
         op_ff        <= req_op;
         cell_x_ff    <= req_cell_x;
         cell_y_ff    <= req_cell_y;
         depth_ff     <= req_depth_in;
         sim_ff       <= req_sim_in;
         fine_addr_ff <= AW'(req_cell_y) * ROW_STEP + AW'(req_cell_x);
         res_depth_ff <= '0;
         res_sim_ff   <= '0;
         res_upd_ff   <= 1'b0;
      end
      if (cmd.coarse_mul) begin
         cxf_ff <= PW'(cell_x_ff) * PW'(factor_ff);
         cyf_ff <= PW'(cell_y_ff) * PW'(factor_ff);
      end
      if (cmd.win_init) begin
         xb0_ff <= x0c_s[XI-1:0];
         xb1_ff <= x1c_s[XI-1:0];
         yb0_ff <= y0c_s[YI-1:0];
         yb1_ff <= y1c_s[YI-1:0];
      end
      if (cmd.fine_commit) begin
         if (op_ff == OP_READ) begin
            res_depth_ff <= in_map ? rd_ff.depth : DEPTH_INVALID;
            res_sim_ff   <= in_map ? rd_ff.sim : SIM_ONE;
         end
         if (do_write) begin
            res_upd_ff <= 1'b1;
         end
      end
      if (cmd.win_wr) begin
         res_upd_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         out_depth_ff <= res_depth_ff;
         out_sim_ff   <= res_sim_ff;
         out_upd_ff   <= res_upd_ff;
      end
   end

   assign status.clear_last = (clr_ff == LAST_ADR);
   assign status.op         = op_ff;
   assign status.din_valid  = din_valid;
   assign status.empty      = (x0c_s > x1c_s) || (y0c_s > y1c_s);
   assign status.win_last   = (x_ff == xb1_ff) && (y_ff == yb1_ff);
   assign status.best       = best_now;

   assign depth_out = out_depth_ff;
   assign sim_out   = out_sim_ff;
   assign updated   = out_upd_ff;

endmodule

// ===== rtl/dsmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Depth map merge controller
// Sequences the clearing pass, cell operations and window scans.
// ----------------------------------------------------------------------------
module dsmm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dsmm_pkg::status_type status,
   output dsmm_pkg::cmd_type    cmd
);
   import dsmm_pkg::*;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_START    = 4'd2;
   localparam logic [3:0] ST_FINE     = 4'd3;
   localparam logic [3:0] ST_BOUNDS   = 4'd4;
   localparam logic [3:0] ST_SCAN     = 4'd5;
   localparam logic [3:0] ST_SCAN_END = 4'd6;
   localparam logic [3:0] ST_WRITE    = 4'd7;
   localparam logic [3:0] ST_FINISH   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            if (status.op != OP_COARSE) begin
               cmd.fine_rd = 1'b1;
               state_in    = ST_FINE;
            end else if (status.din_valid) begin
               cmd.coarse_mul = 1'b1;
               state_in       = ST_BOUNDS;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINE: begin
            cmd.fine_commit = 1'b1;
            state_in        = ST_FINISH;
         end
         ST_BOUNDS: begin
            if (status.empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.win_init = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.win_last) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: begin
            if (status.best) begin
               cmd.win_reload = 1'b1;
               state_in       = ST_WRITE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WRITE: begin
            cmd.win_wr = 1'b1;
            if (status.win_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/depth_sim_map_merge.sv =====
// ----------------------------------------------------------------------------
// Depth/similarity map merge
// Full-resolution depth and similarity map with write, read, same-scale merge
// and coarse window merge operations.
//
//   channel  direction  handshake        contents
//   req_ch   in         valid/ready      op, cell_x, cell_y, depth_in, sim_in
//   rsp_ch   out        valid/ready      depth_out, sim_out, updated
//   csr_*    in         write enable     csr_index, csr_wdata
//
// Write, read and same-scale merge read the cell and then commit the result. A
// coarse merge scans the N covered cells and, when it writes, writes them all
// in a second pass; the single cell memory reads or writes one cell per cycle.
// An empty window or an invalid depth ends a coarse merge before any scan.
// After reset a clearing pass over all MAX_WIDTH * MAX_HEIGHT cells runs before the
// first item is accepted. One result waits in the output register while the
// next item is taken; a further result holds the block until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_sim_map_merge #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_FACTOR = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   dsmm_req_if.sink                req_ch,
   dsmm_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  dsmm_pkg::csr_index_type csr_index,
   input  dsmm_pkg::csr_data_type  csr_wdata
);
   import dsmm_pkg::*;

   cmd_type    cmd;
   status_type status;

   dsmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dsmm_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_op       (req_ch.op),
      .req_cell_x   (req_ch.cell_x),
      .req_cell_y   (req_ch.cell_y),
      .req_depth_in (req_ch.depth_in),
      .req_sim_in   (req_ch.sim_in),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .depth_out    (rsp_ch.depth_out),
      .sim_out      (rsp_ch.sim_out),
      .updated      (rsp_ch.updated)
   );

   `ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.out_load, rsp_ch.valid)
   `ASSERT_ALWAYS(a_one_write_user, clock, reset, $onehot0({cmd.clear, cmd.scan_rd, cmd.win_wr, cmd.fine_commit}))

endmodule
